/* design/sdta_pkg.sv */
// ----------------------------------------------------------------------------
// sdta_pkg: shared types and constants for the signed decimal text encoder
// Holds the sequencer states, the ASCII codes and the default value width.
// ----------------------------------------------------------------------------
package sdta_pkg;

  // Default width of the two's-complement value
  localparam int unsigned DefValueBits = 32;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

/* design/signed_decimal_to_ascii.sv */
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii: signed integer to decimal ASCII text
// Converts one two's-complement word to its magnitude, turns the magnitude
// into BCD one bit per cycle (shift and add-3), then sends a '-' for
// negative words and the digits, most significant first, without leading
// zeros, one character word per cycle once digits start, unless stalled.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------
//   in      | in_valid_i, in_stall_o | value_i, suppress_i
//   out     | out_valid_o, out_stall_i | char_code_o, last_char_o
//
// Sequence: a word is taken only while the sequencer is idle; its magnitude
// is converted bit-serially, a negative word then sends its sign, and each
// of the Digits decimal places is either sent or, if it is a leading zero,
// dropped. A new word is taken only after the last character is loaded.
// A suppressed word is taken without any conversion or output.
// A stall on the output holds the current character, and holds the
// sequencer only when it has a character to load. Reset returns the
// sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module signed_decimal_to_ascii #(
  parameter int unsigned VALUE_BITS = sdta_pkg::DefValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  suppress_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            char_code_o,
  output logic                  last_char_o
);

  import sdta_pkg::*;

  // Decimal places needed for a magnitude up to 2^(VALUE_BITS-1)
  localparam int unsigned Digits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned BcdW   = Digits * 4;
  localparam int unsigned CntW   = $clog2(VALUE_BITS);
  localparam int unsigned DigW   = $clog2(Digits + 1);

  state_e                     state_q, state_d;
  logic [VALUE_BITS-1:0]      mag_q, mag_d;
  logic [Digits-1:0][3:0]     bcd_q, bcd_d;
  logic [Digits-1:0][3:0]     bcd_adj;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [DigW-1:0]            dig_left_q, dig_left_d;
  logic                       neg_q, neg_d;
  logic                       started_q, started_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 char_q, char_d;
  logic                       last_q, last_d;
  logic                       in_accept;
  logic                       out_free;
  logic                       out_load;
  logic [3:0]                 top_digit;
  logic [VALUE_BITS-1:0]      in_mag;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign top_digit   = bcd_q[Digits-1];
  assign in_mag      = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  // Add 3 to every BCD digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  // Sequencer: next state and character load
  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    bcd_d      = bcd_q;
    cnt_d      = cnt_q;
    dig_left_d = dig_left_q;
    neg_d      = neg_q;
    started_d  = started_q;
    out_load   = 1'b0;
    char_d     = char_q;
    last_d     = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && !suppress_i) begin
          mag_d     = in_mag;
          neg_d     = value_i[VALUE_BITS-1];
          bcd_d     = '0;
          cnt_d     = '0;
          started_d = 1'b0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = BcdW'({bcd_adj, mag_q[VALUE_BITS-1]});
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          dig_left_d = DigW'(Digits);
          state_d    = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = CHAR_MINUS;
          last_d   = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (top_digit == 4'd0 && !started_q && dig_left_q != DigW'(1)) begin
          // drop a leading zero
          bcd_d      = {bcd_q[Digits-2:0], 4'h0};
          dig_left_d = dig_left_q - 1'b1;
        end else if (out_free) begin
          out_load   = 1'b1;
          char_d     = CHAR_ZERO + {4'h0, top_digit};
          last_d     = (dig_left_q == DigW'(1));
          bcd_d      = {bcd_q[Digits-2:0], 4'h0};
          dig_left_d = dig_left_q - 1'b1;
          started_d  = 1'b1;
          if (dig_left_q == DigW'(1)) begin
            state_d = ST_IDLE;
          end
        end else begin
          // hold while the character register is full and stalled
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: hold while stalled, load a new word when free
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dig_left_q  <= '0;
      started_q   <= 1'b0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dig_left_q  <= dig_left_d;
      started_q   <= started_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // Conversion ends once the bit counter reaches the last magnitude bit
  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && cnt_q == CntW'(VALUE_BITS - 1))
    |=> (state_q == ST_SIGN || state_q == ST_EMIT))
    else $error("conversion did not finish after VALUE_BITS cycles");

  // Every emitted BCD digit is a decimal digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range");

  // A suppressed word leaves the block idle
  a_suppress_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && suppress_i) |=> (state_q == ST_IDLE && !out_load))
    else $error("suppressed word started a conversion");

  // Loading the final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after final character");

  // Digit count never runs out while emitting
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (dig_left_q != '0))
    else $error("emit state with no digits left");

endmodule
